>>> hdl/qpht_pkg.sv
`default_nettype none
package qpht_pkg;

	localparam int SLOT_BITS_DEF   = 5;
	localparam int PROBE_LIMIT_DEF = 5;
	localparam int KEY_W           = 32;
	localparam int SLOT_OUT_W      = 5;
	localparam int KIND_W          = 2;

	localparam logic [KEY_W-1:0] HASH_SEED = 32'h9e3779b9;
	localparam int HASH_SHL = 6;
	localparam int HASH_SHR = 2;

	typedef logic [1:0] status_t;
	localparam status_t ST_FREE = 2'd0;
	localparam status_t ST_USED = 2'd1;
	localparam status_t ST_TOMB = 2'd2;

	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_FIND   = 2'd1;
	localparam kind_t KIND_DELETE = 2'd2;

	function automatic logic [KEY_W-1:0] key_mix(input logic [KEY_W-1:0] own,
			input logic [KEY_W-1:0] desc);
		logic [KEY_W-1:0] t;
		t = desc + HASH_SEED + (own << HASH_SHL) + (own >> HASH_SHR);
		return own ^ t;
	endfunction

endpackage
`default_nettype wire

>>> hdl/qpht_req_if.sv
`default_nettype none
interface qpht_req_if;
	logic                          valid;
	logic                          ready;
	logic [qpht_pkg::KIND_W-1:0]   kind;
	logic [qpht_pkg::KEY_W-1:0]    owner;
	logic [qpht_pkg::KEY_W-1:0]    descriptor;
	logic [qpht_pkg::KEY_W-1:0]    payload;

	modport source (output valid, kind, owner, descriptor, payload, input ready);
	modport sink (input valid, kind, owner, descriptor, payload, output ready);
endinterface
`default_nettype wire

>>> hdl/qpht_rsp_if.sv
`default_nettype none
interface qpht_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            ok;
	logic [qpht_pkg::SLOT_OUT_W-1:0] slot;
	logic [qpht_pkg::KEY_W-1:0]      found_value;

	modport source (output valid, ok, slot, found_value, input ready);
	modport sink (input valid, ok, slot, found_value, output ready);
endinterface
`default_nettype wire

>>> hdl/qpht_ram.sv
`default_nettype none
module qpht_ram #(
	parameter int ADDR_W = qpht_pkg::SLOT_BITS_DEF,
	parameter int DATA_W = 2
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/quadratic_probe_hash_table_unit.sv
// Flow: an accepted request passes through a hash state, then a read and a check state for
// each probe (1 to PROBE_LIMIT), then a done state; an unused kind goes from hash to done.
// One request at a time: each probe reads and checks the single-ported slot memories, and a
// new request is taken only after the done state, which waits while a result is untaken.
// Reset: arst_n clears control state, then a clearing pass marks every slot free while
// ready stays low.
`default_nettype none
module quadratic_probe_hash_table_unit #(
	parameter int SLOT_BITS   = qpht_pkg::SLOT_BITS_DEF,
	parameter int PROBE_LIMIT = qpht_pkg::PROBE_LIMIT_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	qpht_req_if.sink    req,
	qpht_rsp_if.source  rsp
);

	localparam int KW    = qpht_pkg::KEY_W;
	localparam int PW    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam int ENT_W = 3 * KW;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_DONE} state_t;

	state_t                  state_q;
	logic [SLOT_BITS-1:0]    clr_q;
	qpht_pkg::kind_t         kind_q;
	logic [KW-1:0]           owner_q;
	logic [KW-1:0]           desc_q;
	logic [KW-1:0]           pay_q;
	logic [SLOT_BITS-1:0]    addr_q;
	logic [SLOT_BITS-1:0]    step_q;
	logic [PW-1:0]           cnt_q;
	logic                    res_ok_q;
	logic [SLOT_BITS-1:0]    res_slot_q;
	logic [KW-1:0]           res_val_q;
	logic                    rsp_valid_q;
	logic                    rsp_ok_q;
	logic [qpht_pkg::SLOT_OUT_W-1:0] rsp_slot_q;
	logic [KW-1:0]           rsp_val_q;

	logic                    st_en, st_we;
	logic [SLOT_BITS-1:0]    st_addr;
	qpht_pkg::status_t       st_wdata, st_rdata;
	logic                    ent_en, ent_we;
	logic [ENT_W-1:0]        ent_wdata, ent_rdata;

	logic [KW-1:0]           hash;
	logic                    is_insert, is_delete;
	logic                    key_match, slot_open, ins_take, lookup_hit, lookup_stop;
	logic                    last_probe;

	qpht_ram #(.ADDR_W(SLOT_BITS), .DATA_W(2)) u_status_ram (
		.clk   (clk),
		.en    (st_en),
		.we    (st_we),
		.addr  (st_addr),
		.wdata (st_wdata),
		.rdata (st_rdata)
	);

	qpht_ram #(.ADDR_W(SLOT_BITS), .DATA_W(ENT_W)) u_entry_ram (
		.clk   (clk),
		.en    (ent_en),
		.we    (ent_we),
		.addr  (addr_q),
		.wdata (ent_wdata),
		.rdata (ent_rdata)
	);

	always_comb begin
		hash       = qpht_pkg::key_mix(owner_q, desc_q);
		is_insert  = (kind_q == qpht_pkg::KIND_INSERT);
		is_delete  = (kind_q == qpht_pkg::KIND_DELETE);
		key_match  = (ent_rdata[ENT_W-1 -: KW] == owner_q) &&
		             (ent_rdata[2*KW-1 -: KW] == desc_q);
		slot_open  = (st_rdata == qpht_pkg::ST_FREE) || (st_rdata == qpht_pkg::ST_TOMB);
		ins_take   = (state_q == S_CHECK) && is_insert && slot_open;
		// A tombstone is skipped; any other non-free code counts as a live entry.
		lookup_hit = (state_q == S_CHECK) && !is_insert &&
		             (st_rdata != qpht_pkg::ST_FREE) &&
		             (st_rdata != qpht_pkg::ST_TOMB) && key_match;
		lookup_stop = !is_insert && (st_rdata == qpht_pkg::ST_FREE);
		last_probe = (cnt_q == PW'(PROBE_LIMIT - 1));

		st_we    = (state_q == S_CLEAR) || ins_take || (lookup_hit && is_delete);
		st_en    = st_we || (state_q == S_READ);
		st_addr  = (state_q == S_CLEAR) ? clr_q : addr_q;
		if (state_q == S_CLEAR) begin
			st_wdata = qpht_pkg::ST_FREE;
		end else if (is_insert) begin
			st_wdata = qpht_pkg::ST_USED;
		end else begin
			st_wdata = qpht_pkg::ST_TOMB;
		end
		ent_we    = ins_take;
		ent_en    = ins_take || (state_q == S_READ);
		ent_wdata = {owner_q, desc_q, pay_q};
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.slot        = rsp_slot_q;
	assign rsp.found_value = rsp_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The done state handles the output register itself.
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						kind_q  <= req.kind;
						owner_q <= req.owner;
						desc_q  <= req.descriptor;
						pay_q   <= req.payload;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					addr_q     <= hash[SLOT_BITS-1:0];
					step_q     <= SLOT_BITS'(1);
					cnt_q      <= '0;
					res_ok_q   <= 1'b0;
					res_slot_q <= '0;
					res_val_q  <= '0;
					if (kind_q == qpht_pkg::KIND_INSERT || kind_q == qpht_pkg::KIND_FIND ||
					    kind_q == qpht_pkg::KIND_DELETE) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (ins_take || lookup_hit) begin
						res_ok_q   <= 1'b1;
						res_slot_q <= addr_q;
						if (lookup_hit && !is_delete) begin
							res_val_q <= ent_rdata[KW-1:0];
						end
						state_q <= S_DONE;
					end else if (lookup_stop || last_probe) begin
						state_q <= S_DONE;
					end else begin
						// Successive squares differ by the odd numbers 1, 3, 5, ...
						addr_q  <= addr_q + step_q;
						step_q  <= step_q + SLOT_BITS'(2);
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_ok_q    <= res_ok_q;
						rsp_slot_q  <= qpht_pkg::SLOT_OUT_W'(res_slot_q);
						rsp_val_q   <= res_val_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in progress");

	a_status_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (state_q == S_CLEAR || state_q == S_CHECK))
		else $error("status memory written outside clear or check");

	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ok) |-> (rsp.slot == '0 && rsp.found_value == '0))
		else $error("failed result carries a nonzero slot or value");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (!st_we && !ent_we))
		else $error("memory write during a probe read");

endmodule
`default_nettype wire

>>> verif/quadratic_probe_hash_table_unit_test.sv
`timescale 1ns / 100ps
module quadratic_probe_hash_table_unit_test;

	localparam int KEY_W           = qpht_pkg::KEY_W;
	localparam int SLOT_OUT_W      = qpht_pkg::SLOT_OUT_W;
	localparam int SLOT_W          = qpht_pkg::SLOT_BITS_DEF;
	localparam int PROBES          = qpht_pkg::PROBE_LIMIT_DEF;
	localparam int TABLE_SIZE      = 1 << SLOT_W;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int RSP_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES     = 4 * (2 + 2 * PROBES);
	localparam int MAX_REPORTS     = 10;
	localparam int POOL_SIZE       = 12;
	localparam qpht_pkg::kind_t KIND_SPARE = 2'd3;

	typedef struct packed {
		logic                  ok;
		logic [SLOT_OUT_W-1:0] slot;
		logic [KEY_W-1:0]      found_value;
	} answer_t;

	typedef struct packed {
		logic [KEY_W-1:0] owner;
		logic [KEY_W-1:0] descriptor;
	} table_key_t;

	logic clk;
	logic arst_n;

	qpht_req_if req_ch();
	qpht_rsp_if rsp_ch();

	quadratic_probe_hash_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the slot stores, updated as each request is accepted.
	qpht_pkg::status_t shadow_status     [TABLE_SIZE];
	logic [KEY_W-1:0]  shadow_owner      [TABLE_SIZE];
	logic [KEY_W-1:0]  shadow_descriptor [TABLE_SIZE];
	logic [KEY_W-1:0]  shadow_value      [TABLE_SIZE];

	answer_t expected_answers[$];
	int      mismatch_count = 0;
	int      stalled_cycles = 0;
	bit      req_gaps_on = 1'b0;
	bit      rsp_stalls_on = 1'b0;
	bit      rsp_hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int home_slot(input logic [KEY_W-1:0] owner,
			input logic [KEY_W-1:0] descriptor);
		logic [KEY_W-1:0] mixed;
		mixed = owner ^ (descriptor + qpht_pkg::HASH_SEED + (owner << qpht_pkg::HASH_SHL)
			+ (owner >> qpht_pkg::HASH_SHR));
		return int'(mixed[SLOT_W-1:0]);
	endfunction

	// Picks a descriptor that sends the given owner to the given home slot. The low bits
	// of the sum depend only on the low bits of its operands, so the carry does not matter.
	function automatic logic [KEY_W-1:0] descriptor_for_home(input int home,
			input logic [KEY_W-1:0] owner);
		logic [KEY_W-1:0] target;
		target = $urandom();
		target[SLOT_W-1:0] = owner[SLOT_W-1:0] ^ SLOT_W'(home);
		return target - (qpht_pkg::HASH_SEED + (owner << qpht_pkg::HASH_SHL)
			+ (owner >> qpht_pkg::HASH_SHR));
	endfunction

	function automatic answer_t predict_answer(input qpht_pkg::kind_t kind,
			input logic [KEY_W-1:0] owner, input logic [KEY_W-1:0] descriptor,
			input logic [KEY_W-1:0] payload);
		answer_t ans;
		int      home;
		int      ix;
		int      i;
		bit      done;
		ans = '0;
		done = 1'b0;
		home = home_slot(owner, descriptor);
		if (kind == qpht_pkg::KIND_INSERT) begin
			for (i = 0; i < PROBES && !done; i++) begin
				ix = (home + i * i) % TABLE_SIZE;
				if (shadow_status[ix] == qpht_pkg::ST_FREE ||
						shadow_status[ix] == qpht_pkg::ST_TOMB) begin
					shadow_status[ix] = qpht_pkg::ST_USED;
					shadow_owner[ix] = owner;
					shadow_descriptor[ix] = descriptor;
					shadow_value[ix] = payload;
					ans.ok = 1'b1;
					ans.slot = SLOT_OUT_W'(ix);
					done = 1'b1;
				end
			end
		end else if (kind == qpht_pkg::KIND_FIND || kind == qpht_pkg::KIND_DELETE) begin
			for (i = 0; i < PROBES && !done; i++) begin
				ix = (home + i * i) % TABLE_SIZE;
				if (shadow_status[ix] == qpht_pkg::ST_FREE) begin
					done = 1'b1;
				end else if (shadow_status[ix] != qpht_pkg::ST_TOMB
						&& shadow_owner[ix] == owner
						&& shadow_descriptor[ix] == descriptor) begin
					ans.ok = 1'b1;
					ans.slot = SLOT_OUT_W'(ix);
					if (kind == qpht_pkg::KIND_FIND) begin
						ans.found_value = shadow_value[ix];
					end else begin
						shadow_status[ix] = qpht_pkg::ST_TOMB;
					end
					done = 1'b1;
				end
			end
		end
		return ans;
	endfunction

	task automatic send_request(input qpht_pkg::kind_t kind, input logic [KEY_W-1:0] owner,
			input logic [KEY_W-1:0] descriptor, input logic [KEY_W-1:0] payload);
		if (req_gaps_on && $urandom_range(99) < 10) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.owner <= owner;
		req_ch.descriptor <= descriptor;
		req_ch.payload <= payload;
		do @(posedge clk); while (!req_ch.ready);
		expected_answers.push_back(predict_answer(kind, owner, descriptor, payload));
	endtask

	task automatic wait_answers_drained();
		req_ch.valid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
	endtask

	// Response side: random stalls, plus a long hold-off when a test asks for one.
	initial begin : rsp_receiver
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_request) begin
				hold_left = RSP_HOLD_CYCLES;
				rsp_hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !(rsp_stalls_on && $urandom_range(99) < 10);
			end
		end
	end

	always @(posedge clk) begin : answer_check
		answer_t got;
		answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.ok, rsp_ch.slot, rsp_ch.found_value};
			if (expected_answers.size() == 0) begin
				if (mismatch_count < MAX_REPORTS) begin
					$display(
						"MISMATCH at %0t: unexpected answer ok=%0b slot=%0d value=%h",
						$time, got.ok, got.slot, got.found_value);
				end
				mismatch_count++;
			end else begin
				want = expected_answers.pop_front();
				if (got.ok !== want.ok || got.slot !== want.slot
						|| got.found_value !== want.found_value) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display(
						"MISMATCH at %0t: exp ok=%0b slot=%0d val=%h, got ok=%0b slot=%0d val=%h",
							$time, want.ok, want.slot, want.found_value,
							got.ok, got.slot, got.found_value);
					end
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Fills one probe chain from a clean table and walks through full chains, tombstones,
	// duplicate keys and the unused operation.
	task automatic test_directed_ops();
		logic [KEY_W-1:0] chain_owner [6];
		logic [KEY_W-1:0] chain_desc  [6];
		int               hot;
		int               j;
		hot = 2;
		chain_owner[0] = '0;
		chain_owner[1] = '1;
		chain_owner[2] = $urandom();
		chain_owner[3] = $urandom();
		chain_owner[4] = 32'h8000_0001;
		chain_owner[5] = $urandom();
		for (j = 0; j < 6; j++) begin
			chain_desc[j] = descriptor_for_home(hot, chain_owner[j]);
		end
		send_request(qpht_pkg::KIND_INSERT, '0, '0, '1);
		send_request(qpht_pkg::KIND_FIND, '0, '0, '0);
		send_request(KIND_SPARE, '1, '1, '1);
		for (j = 0; j < 4; j++) begin
			send_request(qpht_pkg::KIND_INSERT, chain_owner[j], chain_desc[j],
				(j == 0) ? '0 : $urandom());
		end
		// A second copy of an existing key takes the last probe position.
		send_request(qpht_pkg::KIND_INSERT, chain_owner[1], chain_desc[1], 32'h5a5a_a5a5);
		send_request(qpht_pkg::KIND_INSERT, chain_owner[4], chain_desc[4], $urandom());
		send_request(qpht_pkg::KIND_FIND, chain_owner[4], chain_desc[4], '1);
		send_request(qpht_pkg::KIND_FIND, chain_owner[3], chain_desc[3], '0);
		send_request(qpht_pkg::KIND_FIND, chain_owner[1], chain_desc[1], '0);
		send_request(qpht_pkg::KIND_DELETE, chain_owner[1], chain_desc[1], '0);
		send_request(qpht_pkg::KIND_FIND, chain_owner[1], chain_desc[1], '0);
		send_request(qpht_pkg::KIND_FIND, chain_owner[2], chain_desc[2], '0);
		send_request(qpht_pkg::KIND_INSERT, chain_owner[5], chain_desc[5], $urandom());
		send_request(qpht_pkg::KIND_DELETE, chain_owner[0], chain_desc[0], '0);
		send_request(qpht_pkg::KIND_FIND, chain_owner[0], chain_desc[0], '0);
		send_request(qpht_pkg::KIND_DELETE, '1, '1, '1);
		send_request(qpht_pkg::KIND_FIND, '1, '1, '0);
		send_request(KIND_SPARE, '0, '0, '0);
		send_request(qpht_pkg::KIND_FIND, chain_owner[5], chain_desc[5], '0);
	endtask

	// Keys are drawn mostly from a small pool clustered on a few home slots, so that
	// inserts, finds and deletes keep meeting each other along the same probe chains.
	task automatic test_random_traffic(input int count);
		table_key_t      pool [POOL_SIZE];
		table_key_t      key;
		int              hot_homes [4];
		int              j;
		int              roll;
		qpht_pkg::kind_t kind;
		for (j = 0; j < 4; j++) begin
			hot_homes[j] = $urandom_range(TABLE_SIZE - 1);
		end
		for (j = 0; j < POOL_SIZE; j++) begin
			roll = $urandom_range(7);
			pool[j].owner = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom();
			pool[j].descriptor = descriptor_for_home(hot_homes[$urandom_range(3)],
				pool[j].owner);
		end
		repeat (count) begin
			if ($urandom_range(99) < 90) begin
				key = pool[$urandom_range(POOL_SIZE - 1)];
			end else begin
				key = '{$urandom(), $urandom()};
			end
			roll = $urandom_range(99);
			kind = (roll < 30) ? qpht_pkg::KIND_INSERT : (roll < 65) ? qpht_pkg::KIND_FIND :
				(roll < 95) ? qpht_pkg::KIND_DELETE : KIND_SPARE;
			send_request(kind, key.owner, key.descriptor, $urandom());
		end
	endtask

	// The receiver holds off long enough for the block to fill and stall new requests.
	task automatic test_output_backpressure();
		rsp_hold_request = 1'b1;
		test_random_traffic(24);
	endtask

	task automatic test_drain_pause();
		test_random_traffic(10);
		wait_answers_drained();
		test_random_traffic(10);
	endtask

	initial begin : test_sequence
		int k;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = qpht_pkg::KIND_INSERT;
		req_ch.owner = '0;
		req_ch.descriptor = '0;
		req_ch.payload = '0;
		for (k = 0; k < TABLE_SIZE; k++) begin
			shadow_status[k] = qpht_pkg::ST_FREE;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_random_traffic(100);
		req_gaps_on = 1'b1;
		rsp_stalls_on = 1'b1;
		test_random_traffic(140);
		test_output_backpressure();
		test_drain_pause();
		test_random_traffic(120);

		wait_answers_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_answers.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
